/* hdl/ook_sensor_frame_transmitter_assert.svh */
// Assertion macros for the OOK sensor frame transmitter.
// Users must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef OOK_SENSOR_FRAME_TRANSMITTER_ASSERT_SVH
`define OOK_SENSOR_FRAME_TRANSMITTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock, disabled while reset is held.
`define OOKT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check a property on every clock, including during reset.
`define OOKT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define OOKT_ASSERT(label, prop, msg)
`define OOKT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* hdl/ookt_pkg.sv */
// Shared types, constants and frame helpers for the OOK sensor frame transmitter.
// No dependencies.
`default_nettype none

package ookt_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 4;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int SEG_BITS    = 6;
    localparam int REP_BITS    = 4;
    localparam int SYNC_BITS   = 3;
    localparam int CFG_IDX_BITS = 3;

    // Checksum seed and temperature offset (adding 128 flips the sign bit)
    localparam logic [7:0] CHECKSUM_SEED = 8'h77;
    localparam logic [7:0] TEMP_OFFSET   = 8'h80;

    // Register reset values
    localparam logic [7:0]           DEVICE_CODE_RST  = 8'd0;
    localparam int                   SHORT_TICKS_RST  = 160;
    localparam int                   LONG_TICKS_RST   = 490;
    localparam int                   SYNC_TICKS_RST   = 1000;
    localparam logic [SYNC_BITS-1:0] SYNC_PULSES_RST  = 3'd5;
    localparam logic [REP_BITS-1:0]  REPEAT_COUNT_RST = 4'd15;

    // Item operation codes
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEVICE_CODE  = 3'd0,
        CFG_SHORT_TICKS  = 3'd1,
        CFG_LONG_TICKS   = 3'd2,
        CFG_SYNC_TICKS   = 3'd3,
        CFG_SYNC_PULSES  = 3'd4,
        CFG_REPEAT_COUNT = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic              op;
        logic signed [7:0] temperature;
        logic        [7:0] humidity;
    } t_in_item;

    typedef struct packed {
        logic tx_level;
        logic busy_res;
        logic done_res;
    } t_out_item;

    function automatic logic [7:0] swap_nibbles(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

    // Build device, humidity, offset temperature and checksum bytes
    function automatic logic [FRAME_BITS-1:0] build_frame(
        input logic [7:0] device_code,
        input logic [7:0] humidity,
        input logic [7:0] temperature
    );
        logic [7:0] t;
        logic [7:0] sum;
        t   = temperature ^ TEMP_OFFSET;
        sum = CHECKSUM_SEED + swap_nibbles(device_code) + swap_nibbles(humidity)
            + swap_nibbles(t);
        return {device_code, humidity, t, swap_nibbles(sum)};
    endfunction

endpackage

`default_nettype wire

/* hdl/ookt_engine.sv */
// Pulse sequencer state and single-pass next-state/result logic.
// Depends on ookt_pkg and ook_sensor_frame_transmitter_assert.svh.
`default_nettype none

`include "ook_sensor_frame_transmitter_assert.svh"

module ookt_engine #(
    parameter int TIMER_BITS = 11
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_step,
    input  wire ookt_pkg::t_in_item                 i_item,
    input  wire logic [7:0]                         i_device_code,
    input  wire logic [TIMER_BITS-1:0]              i_short_ticks,
    input  wire logic [TIMER_BITS-1:0]              i_long_ticks,
    input  wire logic [TIMER_BITS-1:0]              i_sync_ticks,
    input  wire logic [ookt_pkg::SYNC_BITS-1:0]     i_sync_pulses,
    input  wire logic [ookt_pkg::REP_BITS-1:0]      i_repeat_count,
    output ookt_pkg::t_out_item                     o_result
);

    localparam int SB = ookt_pkg::SEG_BITS;
    localparam int RB = ookt_pkg::REP_BITS;

    logic [ookt_pkg::FRAME_BITS-1:0] r_frame_word, n_frame_word;
    logic [RB-1:0]                   r_repeat_index, n_repeat_index;
    logic [SB-1:0]                   r_segment_index, n_segment_index;
    logic                            r_in_sync, n_in_sync;
    logic                            r_high_phase, n_high_phase;
    logic [TIMER_BITS-1:0]           r_phase_ticks, n_phase_ticks;
    logic                            r_active, n_active;

    logic                  w_cur_bit;
    logic [TIMER_BITS-1:0] w_dur;
    logic [TIMER_BITS-1:0] w_dur_eff;
    logic [TIMER_BITS:0]   w_cnt;
    logic [SB-1:0]         w_seg_next;
    logic [RB:0]           w_rep_next;

    // Current data bit, MSB first
    assign w_cur_bit  = r_frame_word[5'(ookt_pkg::FRAME_BITS - 1) - r_segment_index[4:0]];
    assign w_cnt      = {1'b0, r_phase_ticks} + {{TIMER_BITS{1'b0}}, 1'b1};
    assign w_seg_next = r_segment_index + SB'(1);
    assign w_rep_next = {1'b0, r_repeat_index} + (RB+1)'(1);

    // Pick the length of the current phase; zero acts as one tick
    always_comb begin
        if (r_in_sync) begin
            w_dur = i_sync_ticks;
        end else if (w_cur_bit) begin
            w_dur = r_high_phase ? i_short_ticks : i_long_ticks;
        end else begin
            w_dur = r_high_phase ? i_long_ticks : i_short_ticks;
        end
        w_dur_eff = (w_dur == '0) ? TIMER_BITS'(1) : w_dur;
    end

    // Next state and the result for this transfer
    always_comb begin
        n_frame_word    = r_frame_word;
        n_repeat_index  = r_repeat_index;
        n_segment_index = r_segment_index;
        n_in_sync       = r_in_sync;
        n_high_phase    = r_high_phase;
        n_phase_ticks   = r_phase_ticks;
        n_active        = r_active;
        o_result        = '0;

        if (i_item.op == ookt_pkg::OP_START) begin
            if (r_active) begin
                o_result.tx_level = r_high_phase;
            end else begin
                n_frame_word    = ookt_pkg::build_frame(i_device_code, i_item.humidity,
                                                        i_item.temperature);
                n_repeat_index  = '0;
                n_segment_index = '0;
                n_in_sync       = 1'b1;
                n_high_phase    = 1'b0;
                n_phase_ticks   = '0;
                n_active        = 1'b1;
            end
            o_result.busy_res = 1'b1;
        end else if (r_active) begin
            o_result.tx_level = r_high_phase;
            o_result.busy_res = 1'b1;
            if (w_cnt < {1'b0, w_dur_eff}) begin
                n_phase_ticks = w_cnt[TIMER_BITS-1:0];
            end else begin
                n_phase_ticks = '0;
                if (!r_high_phase) begin
                    n_high_phase = 1'b1;
                end else begin
                    n_high_phase = 1'b0;
                    if (r_in_sync) begin
                        // Leave sync after the last sync pulse
                        if (w_seg_next >= {{(SB-ookt_pkg::SYNC_BITS){1'b0}}, i_sync_pulses})
                        begin
                            n_in_sync       = 1'b0;
                            n_segment_index = '0;
                        end else begin
                            n_segment_index = w_seg_next;
                        end
                    end else if (w_seg_next >= SB'(ookt_pkg::FRAME_BITS)) begin
                        // End of frame: repeat or finish
                        n_segment_index = '0;
                        if (w_rep_next >= {1'b0, i_repeat_count}) begin
                            o_result.done_res = 1'b1;
                            n_active          = 1'b0;
                            n_repeat_index    = '0;
                            n_in_sync         = 1'b0;
                        end else begin
                            n_repeat_index = w_rep_next[RB-1:0];
                            n_in_sync      = 1'b1;
                        end
                    end else begin
                        n_segment_index = w_seg_next;
                    end
                end
            end
        end
    end

    // Advance state on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_word    <= '0;
            r_repeat_index  <= '0;
            r_segment_index <= '0;
            r_in_sync       <= 1'b0;
            r_high_phase    <= 1'b0;
            r_phase_ticks   <= '0;
            r_active        <= 1'b0;
        end else if (i_step) begin
            r_frame_word    <= n_frame_word;
            r_repeat_index  <= n_repeat_index;
            r_segment_index <= n_segment_index;
            r_in_sync       <= n_in_sync;
            r_high_phase    <= n_high_phase;
            r_phase_ticks   <= n_phase_ticks;
            r_active        <= n_active;
        end
    end

    `OOKT_ASSERT(a_done_goes_idle, (i_step && o_result.done_res) |=> !r_active, "done without going idle")
    `OOKT_ASSERT(a_idle_clean, !r_active |-> (r_phase_ticks == '0 && !r_high_phase && r_segment_index == '0), "idle with stale sequencer state")
    `OOKT_ASSERT(a_seg_range, r_segment_index < SB'(ookt_pkg::FRAME_BITS), "segment index out of range")

endmodule

`default_nettype wire

/* hdl/ook_sensor_frame_transmitter.sv */
// A result reaches the output register in the cycle after its input transfer.
// Throughput: one item per cycle; input ready drops only while a result waits untaken.
// Each tick item during a frame advances the pin waveform by one step; start items take no time.
// Reset (synchronous, active low) loads register defaults and leaves the sequencer idle.
// Top level of the OOK sensor frame transmitter: configuration, handshake, result register.
// Depends on ookt_pkg, ookt_engine and ook_sensor_frame_transmitter_assert.svh.
`default_nettype none

`include "ook_sensor_frame_transmitter_assert.svh"

module ook_sensor_frame_transmitter #(
    parameter int TIMER_BITS = 11
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire ookt_pkg::t_in_item                  i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output ookt_pkg::t_out_item                      o_out_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [ookt_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [TIMER_BITS-1:0]               i_cfg_data
);

    logic [7:0]                     r_device_code;
    logic [TIMER_BITS-1:0]          r_short_ticks;
    logic [TIMER_BITS-1:0]          r_long_ticks;
    logic [TIMER_BITS-1:0]          r_sync_ticks;
    logic [ookt_pkg::SYNC_BITS-1:0] r_sync_pulses;
    logic [ookt_pkg::REP_BITS-1:0]  r_repeat_count;

    logic                r_out_valid;
    ookt_pkg::t_out_item r_out_item;
    ookt_pkg::t_out_item w_result;
    logic                w_step;

    // Take a new transfer whenever the result register is free or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_step      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_code  <= ookt_pkg::DEVICE_CODE_RST;
            r_short_ticks  <= TIMER_BITS'(ookt_pkg::SHORT_TICKS_RST);
            r_long_ticks   <= TIMER_BITS'(ookt_pkg::LONG_TICKS_RST);
            r_sync_ticks   <= TIMER_BITS'(ookt_pkg::SYNC_TICKS_RST);
            r_sync_pulses  <= ookt_pkg::SYNC_PULSES_RST;
            r_repeat_count <= ookt_pkg::REPEAT_COUNT_RST;
        end else if (i_cfg_we) begin
            case (ookt_pkg::t_cfg_index'(i_cfg_index))
                ookt_pkg::CFG_DEVICE_CODE:  r_device_code  <= i_cfg_data[7:0];
                ookt_pkg::CFG_SHORT_TICKS:  r_short_ticks  <= i_cfg_data;
                ookt_pkg::CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_data;
                ookt_pkg::CFG_SYNC_TICKS:   r_sync_ticks   <= i_cfg_data;
                ookt_pkg::CFG_SYNC_PULSES:  r_sync_pulses  <= i_cfg_data[ookt_pkg::SYNC_BITS-1:0];
                ookt_pkg::CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[ookt_pkg::REP_BITS-1:0];
                default: ;
            endcase
        end
    end

    ookt_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (i_in_item),
        .i_device_code  (r_device_code),
        .i_short_ticks  (r_short_ticks),
        .i_long_ticks   (r_long_ticks),
        .i_sync_ticks   (r_sync_ticks),
        .i_sync_pulses  (r_sync_pulses),
        .i_repeat_count (r_repeat_count),
        .o_result       (w_result)
    );

    // Hold the result until the output transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    `OOKT_ASSERT(a_step_fills_output, w_step |=> r_out_valid, "accepted item produced no result")
    `OOKT_ASSERT(a_done_implies_busy, r_out_valid |-> (!r_out_item.done_res || (r_out_item.busy_res && r_out_item.tx_level)), "done result not busy on high level")
    `OOKT_ASSERT(a_no_step_when_full, (r_out_valid && !i_out_ready) |-> !w_step, "accepted while result stalled")

endmodule

`default_nettype wire
